// ----- rtl/tracker_envelope_generator_assert.svh -----
// Assertion macros shared by the envelope generator RTL
`ifndef TRACKER_ENVELOPE_GENERATOR_ASSERT_SVH
`define TRACKER_ENVELOPE_GENERATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TEG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the clock edge after the antecedent
`define TEG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/teg_pkg.sv -----
// Shared types and constants for the envelope generator
package teg_pkg;
    localparam int MaxNodes = 25;
    localparam int IdxW = 5;
    localparam int TickW = 16;
    localparam int LvlW = 8;
    localparam int NodeW = TickW + LvlW;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_RETRIG  = 2'd2,
        CMD_WRITE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_COUNT     = 3'd1,
        REG_LOOP_ON   = 3'd2,
        REG_LOOP_FST  = 3'd3,
        REG_LOOP_LST  = 3'd4,
        REG_HOLD_ON   = 3'd5,
        REG_HOLD_FST  = 3'd6,
        REG_HOLD_LST  = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,    // read hold-last node
        ST_RD_B,    // read loop-last node
        ST_RD_C,    // read current node
        ST_RD_D,    // read next node
        ST_DECIDE,
        ST_RD_JMP,  // read hold or loop restart node
        ST_LV_A,    // read current node for level
        ST_LV_B,
        ST_LV_C,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic neg;
        logic [31:0] num;   // magnitude of numerator
        logic [16:0] den;
    } div_req_t;

    function automatic logic [IdxW-1:0] fix_idx(input logic [IdxW-1:0] i);
        if (i > IdxW'(MaxNodes - 1)) begin
            return IdxW'(MaxNodes - 1);
        end
        return i;
    endfunction
endpackage

// ----- rtl/tracker_envelope_generator.sv -----
// Top level of the tracker envelope generator
// Multi-node envelope: the node table lives in a 25 x 24-bit RAM with registered
// read, which a sequencer visits one node per cycle. A write, release, retrigger
// or idle tick (envelope disabled or finished) only reads the current and next
// node for the level; an active tick first reads the hold-last, loop-last,
// current and next nodes, decides, and reads the restart node when a hold or loop
// jumps back. When the level falls between two nodes the 32-step serial divider
// used for interpolation runs first. A new transaction is taken once the result
// has moved into the output register; the output holds until m_tready, and a
// result still waiting there stalls the next one. No clearing pass.
`include "tracker_envelope_generator_assert.svh"
module tracker_envelope_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // node_index[4:0], node_tick[20:5], node_level[28:21]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // level[15:0], finished[16], node_now[21:17]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);
    localparam int IdxW = teg_pkg::IdxW;
    localparam int TickW = teg_pkg::TickW;

    teg_pkg::state_t state_reg, state_next;

    logic enable_reg, loop_on_reg, hold_on_reg;
    logic [IdxW-1:0] count_reg, loop_fst_reg, loop_lst_reg, hold_fst_reg, hold_lst_reg;

    logic signed [17:0] pos_reg, pos_next;
    logic [IdxW-1:0] ptr_reg, ptr_next;
    logic fin_reg, fin_next, held_reg, held_next;

    logic [IdxW-1:0] widx_reg, widx_next;
    logic [TickW-1:0] wtick_reg, wtick_next;
    logic [7:0] wlvl_reg, wlvl_next;

    logic [TickW-1:0] tha_reg, tha_next, thb_reg, thb_next, tc_reg, tc_next;
    logic [TickW-1:0] td_reg, td_next;
    logic signed [7:0] yc_reg, yc_next, yd_reg, yd_next;

    logic out_v_reg, out_v_next;
    logic [23:0] out_reg, out_next;

    logic ram_we;
    logic [IdxW-1:0] ram_waddr, ram_raddr;
    logic [teg_pkg::NodeW-1:0] ram_wdata, ram_rdata;
    logic [TickW-1:0] rd_tick;
    logic signed [7:0] rd_lvl;

    teg_pkg::div_req_t dreq;
    logic ddone;
    logic [15:0] dres;

    logic        div_pend_reg;
    logic [15:0] div_res_reg;
    logic        use_div_reg;

    logic [IdxW-1:0] last_idx, cur, nxt;
    logic [IdxW-1:0] hl, ll;
    logic signed [17:0] pinc;
    logic signed [16:0] dx, dd;
    logic signed [24:0] prod_a, prod_b;
    logic signed [25:0] num;

    assign rd_tick = ram_rdata[TickW-1:0];
    assign rd_lvl  = ram_rdata[teg_pkg::NodeW-1:TickW];

    teg_ram #(.Width(teg_pkg::NodeW), .Depth(teg_pkg::MaxNodes)) u_nodes (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    teg_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (dreq),
        .done   (ddone),
        .result (dres)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            count_reg    <= IdxW'(2);
            loop_on_reg  <= 1'b0;
            loop_fst_reg <= '0;
            loop_lst_reg <= '0;
            hold_on_reg  <= 1'b0;
            hold_fst_reg <= '0;
            hold_lst_reg <= '0;
        end else if (cfg_we) begin
            case (teg_pkg::reg_idx_t'(cfg_index))
                teg_pkg::REG_ENABLE:   enable_reg   <= cfg_wdata[0];
                teg_pkg::REG_COUNT:    count_reg    <= cfg_wdata;
                teg_pkg::REG_LOOP_ON:  loop_on_reg  <= cfg_wdata[0];
                teg_pkg::REG_LOOP_FST: loop_fst_reg <= cfg_wdata;
                teg_pkg::REG_LOOP_LST: loop_lst_reg <= cfg_wdata;
                teg_pkg::REG_HOLD_ON:  hold_on_reg  <= cfg_wdata[0];
                teg_pkg::REG_HOLD_FST: hold_fst_reg <= cfg_wdata;
                teg_pkg::REG_HOLD_LST: hold_lst_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= teg_pkg::ST_IDLE;
            pos_reg   <= -18'sd1;
            ptr_reg   <= '0;
            fin_reg   <= 1'b0;
            held_reg  <= 1'b1;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ptr_reg   <= ptr_next;
            fin_reg   <= fin_next;
            held_reg  <= held_next;
            out_v_reg <= out_v_next;
        end
        widx_reg  <= widx_next;
        wtick_reg <= wtick_next;
        wlvl_reg  <= wlvl_next;
        tha_reg   <= tha_next;
        thb_reg   <= thb_next;
        tc_reg    <= tc_next;
        td_reg    <= td_next;
        yc_reg    <= yc_next;
        yd_reg    <= yd_next;
        out_reg   <= out_next;
    end

    always_comb begin
        if (count_reg < IdxW'(2)) begin
            last_idx = IdxW'(1);
        end else if (count_reg > IdxW'(teg_pkg::MaxNodes)) begin
            last_idx = IdxW'(teg_pkg::MaxNodes - 1);
        end else begin
            last_idx = count_reg - IdxW'(1);
        end
        cur  = teg_pkg::fix_idx(ptr_reg);
        nxt  = cur + IdxW'(1);
        hl   = teg_pkg::fix_idx(hold_lst_reg);
        ll   = teg_pkg::fix_idx(loop_lst_reg);
        pinc = (pos_reg < 18'sd65535) ? pos_reg + 18'sd1 : pos_reg;
        dx   = 17'(pos_reg) - $signed({1'b0, tc_reg});
        dd   = $signed({1'b0, td_reg}) - $signed({1'b0, tc_reg});
        prod_a = yc_reg * dd;
        prod_b = (yd_reg - yc_reg) * dx;
        num    = 26'(prod_a) + 26'(prod_b);
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        ptr_next   = ptr_reg;
        fin_next   = fin_reg;
        held_next  = held_reg;
        widx_next  = widx_reg;
        wtick_next = wtick_reg;
        wlvl_next  = wlvl_reg;
        tha_next   = tha_reg;
        thb_next   = thb_reg;
        tc_next    = tc_reg;
        td_next    = td_reg;
        yc_next    = yc_reg;
        yd_next    = yd_reg;
        out_v_next = out_v_reg;
        out_next   = out_reg;
        ram_we     = 1'b0;
        ram_waddr  = widx_reg;
        ram_wdata  = {wlvl_reg, wtick_reg};
        ram_raddr  = cur;
        dreq       = '0;
        s_tready   = 1'b0;

        if (out_v_reg && m_tready) begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            teg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    widx_next  = s_tdata[4:0];
                    wtick_next = s_tdata[20:5];
                    wlvl_next  = s_tdata[28:21];
                    case (teg_pkg::cmd_t'(s_tuser))
                        teg_pkg::CMD_TICK: begin
                            if (enable_reg && !fin_reg) begin
                                pos_next   = pinc;
                                ram_raddr  = hl;
                                state_next = teg_pkg::ST_RD_A;
                            end else begin
                                state_next = teg_pkg::ST_LV_A;
                            end
                        end
                        teg_pkg::CMD_RELEASE: begin
                            held_next  = 1'b0;
                            state_next = teg_pkg::ST_LV_A;
                        end
                        teg_pkg::CMD_RETRIG: begin
                            pos_next   = -18'sd1;
                            ptr_next   = '0;
                            fin_next   = 1'b0;
                            held_next  = 1'b1;
                            state_next = teg_pkg::ST_LV_A;
                        end
                        default: begin
                            if (s_tdata[4:0] < IdxW'(teg_pkg::MaxNodes)) begin
                                ram_we    = 1'b1;
                                ram_waddr = s_tdata[4:0];
                                ram_wdata = {s_tdata[28:21], s_tdata[20:5]};
                            end
                            state_next = teg_pkg::ST_LV_A;
                        end
                    endcase
                end
            end
            teg_pkg::ST_RD_A: begin
                tha_next   = rd_tick;
                ram_raddr  = ll;
                state_next = teg_pkg::ST_RD_B;
            end
            teg_pkg::ST_RD_B: begin
                thb_next   = rd_tick;
                ram_raddr  = cur;
                state_next = teg_pkg::ST_RD_C;
            end
            teg_pkg::ST_RD_C: begin
                tc_next    = rd_tick;
                ram_raddr  = (cur < last_idx) ? nxt : cur;
                state_next = teg_pkg::ST_RD_D;
            end
            teg_pkg::ST_RD_D: begin
                td_next    = rd_tick;
                state_next = teg_pkg::ST_DECIDE;
            end
            teg_pkg::ST_DECIDE: begin
                state_next = teg_pkg::ST_LV_A;
                if (held_reg && hold_on_reg && pos_reg > $signed({2'b0, tha_reg})) begin
                    ptr_next   = teg_pkg::fix_idx(hold_fst_reg);
                    ram_raddr  = teg_pkg::fix_idx(hold_fst_reg);
                    state_next = teg_pkg::ST_RD_JMP;
                end else if ((!held_reg || !hold_on_reg) && loop_on_reg
                             && pos_reg > $signed({2'b0, thb_reg})) begin
                    ptr_next   = teg_pkg::fix_idx(loop_fst_reg);
                    ram_raddr  = teg_pkg::fix_idx(loop_fst_reg);
                    state_next = teg_pkg::ST_RD_JMP;
                end else if (cur < last_idx && pos_reg >= $signed({2'b0, td_reg})) begin
                    ptr_next = nxt;
                end else if (cur >= last_idx) begin
                    ptr_next = cur;
                    pos_next = $signed({2'b0, tc_reg});
                    fin_next = 1'b1;
                end
            end
            teg_pkg::ST_RD_JMP: begin
                pos_next   = $signed({2'b0, rd_tick});
                state_next = teg_pkg::ST_LV_A;
            end
            teg_pkg::ST_LV_A: begin
                ram_raddr  = cur;
                state_next = teg_pkg::ST_LV_B;
            end
            teg_pkg::ST_LV_B: begin
                tc_next    = rd_tick;
                yc_next    = rd_lvl;
                ram_raddr  = (cur < last_idx) ? nxt : cur;
                state_next = teg_pkg::ST_LV_C;
            end
            teg_pkg::ST_LV_C: begin
                td_next = rd_tick;
                yd_next = rd_lvl;
                state_next = teg_pkg::ST_OUT;
                if (pos_reg > $signed({2'b0, tc_reg}) && cur < last_idx
                    && rd_tick > tc_reg) begin
                    state_next = teg_pkg::ST_DIV;
                end
            end
            teg_pkg::ST_DIV: begin
                // numerator y0*d + (y1-y0)*x, scaled by 256 and divided by d;
                // its magnitude stays below 2^23
                dreq.start = 1'b1;
                dreq.neg   = num[25];
                dreq.num   = {num[25] ? 24'(-num) : 24'(num), 8'd0};
                dreq.den   = 17'(dd);
                state_next = teg_pkg::ST_OUT;
            end
            teg_pkg::ST_OUT: begin
                // wait for the divider and for room in the output register
                if (!out_v_next && !div_pend_reg && !ddone) begin
                    out_next   = {2'b0, ptr_reg, fin_reg,
                                  use_div_reg ? div_res_reg : {yc_reg, 8'd0}};
                    out_v_next = 1'b1;
                    state_next = teg_pkg::ST_IDLE;
                end
            end
            default: state_next = teg_pkg::ST_IDLE;
        endcase
    end

    // level for the output: divider result when interpolating, else y0 * 256
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_pend_reg <= 1'b0;
        end else if (dreq.start) begin
            div_pend_reg <= 1'b1;
        end else if (ddone) begin
            div_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ddone) begin
            div_res_reg <= dres;
        end
        if (dreq.start) begin
            use_div_reg <= 1'b1;
        end else if (state_reg == teg_pkg::ST_LV_A) begin
            use_div_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    `TEG_ASSERT_IMP(a_busy_no_ready, aclk, aresetn, state_reg != teg_pkg::ST_IDLE, !s_tready)
    `TEG_ASSERT_IMP(a_ptr_range, aclk, aresetn, 1'b1, ptr_reg < IdxW'(teg_pkg::MaxNodes))
    `TEG_ASSERT_NEXT(a_out_load, aclk, aresetn,
        state_reg == teg_pkg::ST_OUT && state_next == teg_pkg::ST_IDLE, m_tvalid)
endmodule

// ----- rtl/teg_ram.sv -----
// Generic single-port-write, registered-read RAM
module teg_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/teg_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, signed result saturated
`include "tracker_envelope_generator_assert.svh"
module teg_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  teg_pkg::div_req_t req,
    output logic              done,
    output logic [15:0]       result
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [16:0] den_reg, den_next;
    logic [17:0] trial;
    logic [31:0] mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        den_reg <= den_next;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        done      = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            quo_next  = req.num;
            rem_next  = '0;
            neg_next  = req.neg;
            den_next  = req.den;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
                if (!trial[17]) begin
                    rem_next = trial[16:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[15:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
        end
    end

    // truncation toward zero: divide magnitudes, then apply sign and clamp
    always_comb begin
        mag = quo_reg;
        if (neg_reg) begin
            result = (mag > 32'd32768) ? 16'sh8000 : 16'(~mag + 32'd1);
        end else begin
            result = (mag > 32'd32767) ? 16'h7fff : mag[15:0];
        end
    end

    `TEG_ASSERT_IMP(a_done_busy, aclk, aresetn, done, busy_reg)
    `TEG_ASSERT_NEXT(a_start_busy, aclk, aresetn, req.start, busy_reg && cnt_reg == 6'd32)
    `TEG_ASSERT_IMP(a_den_nz, aclk, aresetn, busy_reg, den_reg != 17'd0)
endmodule
